@@ rtl/core/cmee_pkg.sv @@
// Shared types, codes and arithmetic helpers for the CI matrix element engine.
// Depends on nothing; every other file but cmee_ram imports it.
package cmee_pkg;

    // Function codes of the input beat
    localparam logic [1:0] FUNC_WR_ONE = 2'd0;
    localparam logic [1:0] FUNC_WR_TWO = 2'd1;
    localparam logic [1:0] FUNC_EVAL   = 2'd2;
    localparam logic [1:0] FUNC_NONE   = 2'd3;

    // Excitation levels of a result
    localparam logic [1:0] LVL_DIAG   = 2'd0;
    localparam logic [1:0] LVL_SINGLE = 2'd1;
    localparam logic [1:0] LVL_DOUBLE = 2'd2;
    localparam logic [1:0] LVL_NONE   = 2'd3;

    // Largest table index the input field can name, plus one
    localparam int IDX_SPAN = 4096;

    localparam logic signed [63:0] VAL_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] VAL_MIN = 64'sh8000_0000_0000_0000;

    typedef enum logic [1:0] {
        TK_WR_ONE,
        TK_WR_TWO,
        TK_EVAL
    } t_kind;

    typedef enum logic [1:0] {
        RD_FIRST,
        RD_SECOND,
        RD_ONLY
    } t_rdkind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DH,
        S_DE,
        S_SH,
        S_SE,
        S_DB,
        S_TAIL,
        S_DRAIN,
        S_FIN
    } t_state;

    typedef struct packed {
        logic [1:0]         func;
        logic [11:0]        table_index;
        logic signed [63:0] table_value;
        logic [7:0]         first_alpha;
        logic [7:0]         first_beta;
        logic [7:0]         second_alpha;
        logic [7:0]         second_beta;
    } t_in_item;

    typedef struct packed {
        logic signed [63:0] matrix_element;
        logic [1:0]         excitation_level;
    } t_out_item;

    // Classified work passed from front to back
    typedef struct packed {
        t_kind              kind;
        logic [11:0]        idx;
        logic signed [63:0] value;
        logic [15:0]        occ;
        logic [1:0]         level;
        logic [3:0]         p;
        logic [3:0]         q;
        logic [3:0]         a;
        logic [3:0]         b;
        logic               ph;
        logic               same;
    } t_task;

    // Read descriptor that follows a table read down the pipe
    typedef struct packed {
        logic    vld;
        t_rdkind kind;
        logic    src_two;
        logic    zero;
        logic    dest_h;
        logic    last;
    } t_rd;

    function automatic logic signed [63:0] clamp65(input logic signed [64:0] s);
        logic signed [63:0] r;
        if (s[64] != s[63]) begin
            r = s[64] ? VAL_MIN : VAL_MAX;
        end else begin
            r = s[63:0];
        end
        return r;
    endfunction

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] x,
                                                   input logic signed [63:0] y);
        logic signed [64:0] s;
        s = {x[63], x} + {y[63], y};
        return clamp65(s);
    endfunction

    function automatic logic signed [63:0] sat_sub(input logic signed [63:0] x,
                                                   input logic signed [63:0] y);
        logic signed [64:0] s;
        s = {x[63], x} - {y[63], y};
        return clamp65(s);
    endfunction

    // Interleave spatial masks: spin orbital 2p+spin
    function automatic logic [15:0] spin_word(input logic [7:0] al, input logic [7:0] be);
        logic [15:0] w;
        for (int p = 0; p < 8; p++) begin
            w[2*p]   = al[p];
            w[2*p+1] = be[p];
        end
        return w;
    endfunction

    // Index of lowest set bit, zero when none
    function automatic logic [3:0] low_bit(input logic [15:0] w);
        logic [3:0] r;
        r = 4'd0;
        for (int i = 15; i >= 0; i--) begin
            if (w[i]) r = 4'(i);
        end
        return r;
    endfunction

    function automatic logic [4:0] popcnt16(input logic [15:0] w);
        logic [4:0] c;
        c = 5'd0;
        for (int i = 0; i < 16; i++) c = c + {4'd0, w[i]};
        return c;
    endfunction

    function automatic logic [15:0] bit16(input logic [3:0] s);
        return 16'h1 << s;
    endfunction

    // Odd count of occupied spin orbitals below s
    function automatic logic par_below(input logic [15:0] occ, input logic [3:0] s);
        return ^(occ & (bit16(s) - 16'h1));
    endfunction

endpackage

@@ rtl/core/cmee_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module cmee_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/cmee_front.sv @@
// Front end: takes input beats and classifies them into table writes or
// determinant pair evaluations (level, differing orbitals, phase). Uses cmee_pkg.
module cmee_front import cmee_pkg::*; #(
    parameter int NUM_ORBITALS = 8
) (
    input  logic     i_valid,
    output logic     o_stall,
    input  t_in_item i_item,
    input  logic     i_full,
    output logic     o_push,
    output t_task    o_task
);

    localparam logic [7:0] OM = (NUM_ORBITALS >= 8) ? 8'hFF
                                                    : 8'((1 << NUM_ORBITALS) - 1);

    logic [15:0] occ_i, occ_j, di, dj;
    logic [4:0]  ndi, ndj;
    logic [3:0]  p, q, a0, b0;
    logic [15:0] st;
    logic        same, swap;

    assign o_stall = i_full;

    // Classify one beat
    always_comb begin
        occ_i = spin_word(i_item.first_alpha & OM, i_item.first_beta & OM);
        occ_j = spin_word(i_item.second_alpha & OM, i_item.second_beta & OM);
        di    = occ_i & ~occ_j;
        dj    = occ_j & ~occ_i;
        ndi   = popcnt16(di);
        ndj   = popcnt16(dj);
        p     = low_bit(di);
        q     = low_bit(di & ~bit16(p));
        a0    = low_bit(dj);
        b0    = low_bit(dj & ~bit16(a0));
        same  = (p[0] == q[0]) && (a0[0] == b0[0]) && (p[0] == a0[0]);
        swap  = !same && ((p[0] ^ a0[0]) || (q[0] ^ b0[0]));

        o_task       = '0;
        o_task.idx   = i_item.table_index;
        o_task.value = i_item.table_value;
        o_task.occ   = occ_i;
        o_task.p     = p;
        o_task.same  = same;
        o_task.a     = swap ? b0 : a0;
        o_task.b     = swap ? a0 : b0;

        if (ndi == 5'd0 && ndj == 5'd0) begin
            o_task.level = LVL_DIAG;
        end else if (ndi == 5'd1 && ndj == 5'd1) begin
            o_task.level = LVL_SINGLE;
        end else if (ndi == 5'd2 && ndj == 5'd2) begin
            o_task.level = LVL_DOUBLE;
        end else begin
            o_task.level = LVL_NONE;
        end

        // Phase: annihilate p then q, create a then b; a single has only p and a
        st = '0;
        if (o_task.level == LVL_SINGLE) begin
            o_task.q  = a0;
            o_task.ph = par_below(occ_i, p) ^ par_below(occ_i & ~bit16(p), a0);
        end else begin
            o_task.q  = q;
            st        = occ_i & ~bit16(p) & ~bit16(q);
            o_task.ph = par_below(occ_i, p) ^ par_below(occ_i & ~bit16(p), q)
                      ^ par_below(st, o_task.a)
                      ^ par_below(st | bit16(o_task.a), o_task.b);
        end

        case (i_item.func)
            FUNC_WR_ONE: o_task.kind = TK_WR_ONE;
            FUNC_WR_TWO: o_task.kind = TK_WR_TWO;
            default:     o_task.kind = TK_EVAL;
        endcase

        o_push = i_valid && !i_full && (i_item.func != FUNC_NONE);
    end

endmodule

@@ rtl/core/cmee_queue.sv @@
// Two-entry queue of classified work between front and back.
// Uses cmee_pkg for the entry type.
module cmee_queue import cmee_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_task i_task,
    output logic  o_full,
    output logic  o_empty,
    input  logic  i_pop,
    output t_task o_task
);

    t_task      r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_task  = r_mem[r_rp];

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_task;
    end

    // Pointers and fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

@@ rtl/core/cmee_back.sv @@
// Back end: table memories, read sequencer, accumulate pipe and result register.
// Uses cmee_pkg and cmee_ram.
module cmee_back import cmee_pkg::*; #(
    parameter int NUM_ORBITALS = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_empty,
    input  t_task     i_task,
    output logic      o_pop,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);

    localparam int ONE_DEPTH = NUM_ORBITALS * NUM_ORBITALS;
    localparam int TWO_FULL  = ONE_DEPTH * ONE_DEPTH;
    localparam int TWO_DEPTH = (TWO_FULL > IDX_SPAN) ? IDX_SPAN : TWO_FULL;
    localparam int ONE_AW    = $clog2(ONE_DEPTH);
    localparam int TWO_AW    = $clog2(TWO_DEPTH);
    localparam logic [12:0] ONE_LIM = 13'(ONE_DEPTH);
    localparam logic [12:0] TWO_LIM = 13'(TWO_DEPTH);
    localparam logic [15:0] N16     = 16'(NUM_ORBITALS);

    // Spin-orbital addressing
    function automatic logic [15:0] h_addr(input logic [3:0] s, input logic [3:0] t);
        return 16'(s[3:1]) * N16 + 16'(t[3:1]);
    endfunction

    function automatic logic [15:0] eri_addr(input logic [3:0] p, input logic [3:0] q,
                                             input logic [3:0] r, input logic [3:0] s);
        return ((16'(p[3:1]) * N16 + 16'(r[3:1])) * N16 + 16'(q[3:1])) * N16
               + 16'(s[3:1]);
    endfunction

    t_state r_state, n_state;
    t_task  r_tk, n_tk;
    logic [3:0]  r_k, n_k;
    logic [15:0] r_krem, n_krem, r_mrem, n_mrem;
    logic        r_sub, n_sub;

    t_rd   iss, r_s1, r_s2, s1_fwd;
    logic  wr_one, wr_two, clr_acc, load_out;
    logic [15:0] one_a, two_a;
    logic [63:0] one_rd, two_rd;
    logic signed [63:0] rd_val, r_a, r_d, r_hacc, r_pacc, fin_val;
    logic        r_out_vld;
    t_out_item   r_out;

    // Sequencer helpers
    logic [3:0]  lo_k, lo_m, lo_occ;
    logic [15:0] krem_nx, mrem_nx, krem_sh;

    always_comb begin
        lo_k    = low_bit(r_krem);
        lo_m    = low_bit(r_mrem);
        lo_occ  = low_bit(r_tk.occ);
        krem_nx = r_krem & ~bit16(lo_k);
        mrem_nx = r_mrem & ~bit16(lo_m);
        krem_sh = r_tk.occ & ~bit16(r_tk.p);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (!i_empty && i_task.kind == TK_EVAL) begin
                    case (i_task.level)
                        LVL_DIAG:   n_state = S_DH;
                        LVL_SINGLE: n_state = S_SH;
                        LVL_DOUBLE: n_state = S_DB;
                        default:    n_state = S_TAIL;
                    endcase
                end
            end
            S_DH: begin
                if (r_krem == 16'd0) n_state = (r_tk.occ == 16'd0) ? S_TAIL : S_DE;
            end
            S_DE: begin
                if (r_sub && mrem_nx == 16'd0 && r_krem == 16'd0) n_state = S_TAIL;
            end
            S_SH: begin
                n_state = (krem_sh == 16'd0) ? S_TAIL : S_SE;
            end
            S_SE: begin
                if (r_sub && krem_nx == 16'd0) n_state = S_TAIL;
            end
            S_DB: begin
                if (!r_tk.same || r_sub) n_state = S_TAIL;
            end
            S_TAIL:  n_state = S_DRAIN;
            S_DRAIN: begin
                if (r_s2.vld && r_s2.last) n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_out_vld || !i_stall) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs: reads to issue, writes, loop counters
    always_comb begin
        iss      = '0;
        one_a    = 16'd0;
        two_a    = 16'd0;
        o_pop    = 1'b0;
        wr_one   = 1'b0;
        wr_two   = 1'b0;
        clr_acc  = 1'b0;
        load_out = 1'b0;
        n_tk     = r_tk;
        n_k      = r_k;
        n_krem   = r_krem;
        n_mrem   = r_mrem;
        n_sub    = r_sub;
        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    case (i_task.kind)
                        TK_WR_ONE: wr_one = ({1'b0, i_task.idx} < ONE_LIM);
                        TK_WR_TWO: wr_two = ({1'b0, i_task.idx} < TWO_LIM);
                        default: begin
                            n_tk    = i_task;
                            clr_acc = 1'b1;
                            n_krem  = i_task.occ;
                            n_sub   = 1'b0;
                        end
                    endcase
                end
            end
            S_DH: begin
                if (r_krem != 16'd0) begin
                    iss.vld    = 1'b1;
                    iss.kind   = RD_ONLY;
                    iss.dest_h = 1'b1;
                    one_a      = h_addr(lo_k, lo_k);
                    n_krem     = krem_nx;
                end else begin
                    n_k    = lo_occ;
                    n_krem = r_tk.occ & ~bit16(lo_occ);
                    n_mrem = r_tk.occ;
                    n_sub  = 1'b0;
                end
            end
            S_DE: begin
                iss.vld     = 1'b1;
                iss.src_two = 1'b1;
                if (!r_sub) begin
                    iss.kind = RD_FIRST;
                    two_a    = eri_addr(r_k, lo_m, r_k, lo_m);
                    n_sub    = 1'b1;
                end else begin
                    iss.kind = RD_SECOND;
                    iss.zero = r_k[0] ^ lo_m[0];
                    two_a    = eri_addr(r_k, lo_m, lo_m, r_k);
                    n_sub    = 1'b0;
                    n_mrem   = mrem_nx;
                    if (mrem_nx == 16'd0 && r_krem != 16'd0) begin
                        n_k    = lo_k;
                        n_krem = krem_nx;
                        n_mrem = r_tk.occ;
                    end
                end
            end
            S_SH: begin
                iss.vld  = 1'b1;
                iss.kind = RD_ONLY;
                iss.zero = r_tk.p[0] ^ r_tk.q[0];
                one_a    = h_addr(r_tk.p, r_tk.q);
                n_krem   = krem_sh;
                n_sub    = 1'b0;
            end
            S_SE: begin
                iss.vld     = 1'b1;
                iss.src_two = 1'b1;
                if (!r_sub) begin
                    iss.kind = RD_FIRST;
                    iss.zero = r_tk.p[0] ^ r_tk.q[0];
                    two_a    = eri_addr(r_tk.p, lo_k, r_tk.q, lo_k);
                    n_sub    = 1'b1;
                end else begin
                    iss.kind = RD_SECOND;
                    iss.zero = (r_tk.p[0] ^ lo_k[0]) | (lo_k[0] ^ r_tk.q[0]);
                    two_a    = eri_addr(r_tk.p, lo_k, lo_k, r_tk.q);
                    n_sub    = 1'b0;
                    n_krem   = krem_nx;
                end
            end
            S_DB: begin
                iss.vld     = 1'b1;
                iss.src_two = 1'b1;
                if (!r_tk.same) begin
                    iss.kind = RD_ONLY;
                    iss.zero = (r_tk.p[0] ^ r_tk.a[0]) | (r_tk.q[0] ^ r_tk.b[0]);
                    two_a    = eri_addr(r_tk.p, r_tk.q, r_tk.a, r_tk.b);
                end else if (!r_sub) begin
                    iss.kind = RD_FIRST;
                    two_a    = eri_addr(r_tk.p, r_tk.q, r_tk.a, r_tk.b);
                    n_sub    = 1'b1;
                end else begin
                    iss.kind = RD_SECOND;
                    two_a    = eri_addr(r_tk.p, r_tk.q, r_tk.b, r_tk.a);
                    n_sub    = 1'b0;
                end
            end
            S_TAIL: begin
                iss.vld  = 1'b1;
                iss.kind = RD_ONLY;
                iss.zero = 1'b1;
                iss.last = 1'b1;
            end
            S_FIN: begin
                load_out = !r_out_vld || !i_stall;
            end
            default: begin
            end
        endcase
    end

    // Integral tables
    cmee_ram #(.WIDTH(64), .DEPTH(ONE_DEPTH)) u_one (
        .i_clk   (i_clk),
        .i_we    (wr_one),
        .i_waddr (i_task.idx[ONE_AW-1:0]),
        .i_wdata (i_task.value),
        .i_raddr (one_a[ONE_AW-1:0]),
        .o_rdata (one_rd)
    );

    cmee_ram #(.WIDTH(64), .DEPTH(TWO_DEPTH)) u_two (
        .i_clk   (i_clk),
        .i_we    (wr_two),
        .i_waddr (i_task.idx[TWO_AW-1:0]),
        .i_wdata (i_task.value),
        .i_raddr (two_a[TWO_AW-1:0]),
        .o_rdata (two_rd)
    );

    // Read data lines up with the registered descriptor
    assign rd_val = r_s1.zero ? 64'sd0 : (r_s1.src_two ? $signed(two_rd) : $signed(one_rd));

    // Second stage only carries terms that are complete
    always_comb begin
        s1_fwd     = r_s1;
        s1_fwd.vld = r_s1.vld && (r_s1.kind != RD_FIRST);
    end

    // Final element from the accumulators
    always_comb begin
        case (r_tk.level)
            LVL_DIAG:   fin_val = sat_add(r_hacc, r_pacc >>> 1);
            LVL_SINGLE,
            LVL_DOUBLE: fin_val = r_tk.ph ? sat_sub(64'sd0, r_pacc) : r_pacc;
            default:    fin_val = 64'sd0;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_s1      <= '0;
            r_s2      <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_s1    <= iss;
            r_s2    <= s1_fwd;
            if (load_out) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload and datapath registers
    always_ff @(posedge i_clk) begin
        r_tk   <= n_tk;
        r_k    <= n_k;
        r_krem <= n_krem;
        r_mrem <= n_mrem;
        r_sub  <= n_sub;
        // term: first read held, second read subtracted
        if (r_s1.kind == RD_FIRST) r_a <= rd_val;
        r_d <= (r_s1.kind == RD_SECOND) ? sat_sub(r_a, rd_val) : rd_val;
        // accumulate
        if (clr_acc) begin
            r_hacc <= 64'sd0;
            r_pacc <= 64'sd0;
        end else if (r_s2.vld) begin
            if (r_s2.dest_h) r_hacc <= sat_add(r_hacc, r_d);
            else             r_pacc <= sat_add(r_pacc, r_d);
        end
        if (load_out) begin
            r_out.matrix_element   <= fin_val;
            r_out.excitation_level <= r_tk.level;
        end
    end

    assign o_valid = r_out_vld;
    assign o_item  = r_out;

endmodule

@@ rtl/core/ci_matrix_element_engine_top.sv @@
// A write beat reaches its table when the idle back end pops it from the queue. An
// evaluate beat issues its table reads one after another: with n occupied spin
// orbitals a diagonal is n + 2n^2 reads (up to 528), a single 2n-1, a double 1-2.
// Throughput is set by the one read port per table; one item at a time.
// Reset clears control state only; the tables hold nothing until written.
module ci_matrix_element_engine_top import cmee_pkg::*; #(
    parameter int NUM_ORBITALS = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);

    logic  push, full, empty, pop;
    t_task f_task, q_task;

    cmee_front #(.NUM_ORBITALS(NUM_ORBITALS)) u_front (
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .i_full  (full),
        .o_push  (push),
        .o_task  (f_task)
    );

    cmee_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_task  (f_task),
        .o_full  (full),
        .o_empty (empty),
        .i_pop   (pop),
        .o_task  (q_task)
    );

    cmee_back #(.NUM_ORBITALS(NUM_ORBITALS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_task  (q_task),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

endmodule

@@ rtl/core/cmee_checker.sv @@
// Port-level checks on the engine top, attached by bind.
// Uses cmee_pkg for the result type and level codes.
module cmee_checker import cmee_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_stall,
    input logic      o_valid,
    input logic      i_stall,
    input t_out_item o_item
);

    // A stalled result beat stays
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result beat dropped while stalled");

    // A stalled result beat keeps its payload
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_item))
        else $error("result payload changed while stalled");

    // Reset empties both sides
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("not idle after reset");

    // Unconnected pairs give a zero element
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_item.excitation_level != LVL_NONE) || (o_item.matrix_element == 64'sd0))
        else $error("nonzero element for unconnected pair");

endmodule

bind ci_matrix_element_engine_top cmee_checker u_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_item  (o_item)
);
